// ===== sv/hcg_pkg.sv =====
// hcg_pkg: types, constants and the sectors-per-track table for the CHS geometry block.
// Depends on nothing; imported by every other file of the block.
package hcg_pkg;

  localparam int SIZE_W = 32;
  localparam int TOT_W  = 23;   // total sectors: size >> 9
  localparam int DIV_W  = 12;   // heads * spt, at most 16 * 255
  localparam int CNT_W  = 5;
  localparam int CYL_W  = 16;
  localparam int HEAD_W = 5;
  localparam int SPT_W  = 8;
  localparam int SEC_SHIFT = 9;

  localparam logic [SIZE_W-1:0] SMALL_LIMIT = 32'h2000_0000;   // 512 MiB
  localparam logic [TOT_W-1:0]  CYL_SMALL_MAX = 23'd1023;
  localparam logic [TOT_W-1:0]  CYL_LIM_A     = 23'd16383;
  localparam logic [TOT_W-1:0]  CYL_LIM_B     = 23'd32767;
  localparam logic [CYL_W-1:0]  CYL_SAT       = 16'hFFFF;

  localparam logic [HEAD_W-1:0] HEAD_MIN  = 5'd4;
  localparam logic [HEAD_W-1:0] HEAD_MAX  = 5'd16;
  localparam logic [HEAD_W-1:0] HEAD_WIDE = 5'd5;

  localparam logic [1:0] SPT_IDX_FIRST = 2'd0;
  localparam logic [1:0] SPT_IDX_LAST  = 2'd2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TOT_W - 1);

  localparam logic [SPT_W-1:0] SPT_63  = 8'd63;
  localparam logic [SPT_W-1:0] SPT_127 = 8'd127;
  localparam logic [SPT_W-1:0] SPT_255 = 8'd255;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_CHECK = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  function automatic logic [SPT_W-1:0] spt_of(input logic [1:0] idx);
    logic [SPT_W-1:0] v;
    case (idx)
      2'd0:    v = SPT_63;
      2'd1:    v = SPT_127;
      default: v = SPT_255;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/hcg_in_if.sv =====
// hcg_in_if: input channel of the CHS geometry block (valid/ready plus image size).
// Depends on hcg_pkg.
interface hcg_in_if import hcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_bytes;

  modport source (output valid, output size_bytes, input ready);
  modport sink   (input valid, input size_bytes, output ready);
  modport mon    (input valid, input size_bytes, input ready);
endinterface

// ===== sv/hcg_out_if.sv =====
// hcg_out_if: result channel of the CHS geometry block (valid/ready plus geometry).
// Depends on hcg_pkg.
interface hcg_out_if import hcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [CYL_W-1:0]  cylinders;
  logic [HEAD_W-1:0] heads;
  logic [SPT_W-1:0]  sectors_per_track;

  modport source (output valid, output valid_res, output cylinders, output heads,
                  output sectors_per_track, input ready);
  modport sink   (input valid, input valid_res, input cylinders, input heads,
                  input sectors_per_track, output ready);
  modport mon    (input valid, input valid_res, input cylinders, input heads,
                  input sectors_per_track, input ready);
endinterface

// ===== sv/hardfile_chs_geometry.sv =====
// hardfile_chs_geometry: picks a cylinder/head/sector geometry from a disk image size.
// Depends on hcg_pkg, hcg_in_if and hcg_out_if.
//
//   channel   dir   payload                                        handshake
//   in_ch     in    size_bytes[31:0]                               valid/ready
//   out_ch    out   valid_res, cylinders[15:0], heads[4:0], spt    valid/ready
//
// One item at a time. Each (spt, heads) trial is a bit-serial restoring divide of the
// 23-bit sector count, one quotient bit per cycle, followed by one fit check.
// An item takes at most 39 trials; a zero size skips the divide and goes straight to done.
// Synchronous active-low reset clears control only. A result waits in the output
// register while out_ch.ready is low; the next item is taken meanwhile.
module hardfile_chs_geometry import hcg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hcg_in_if.sink    in_ch,
  hcg_out_if.source out_ch
);

  state_t state_r, state_nxt;

  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic              small_r, small_nxt;
  logic [TOT_W-1:0]  work_r, work_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        sidx_r, sidx_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;

  logic              res_valid_r, res_valid_nxt;
  logic [CYL_W-1:0]  res_cyl_r, res_cyl_nxt;
  logic [HEAD_W-1:0] res_head_r, res_head_nxt;
  logic [SPT_W-1:0]  res_spt_r, res_spt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_vres_r;
  logic [CYL_W-1:0]  out_cyl_r;
  logic [HEAD_W-1:0] out_head_r;
  logic [SPT_W-1:0]  out_spt_r;

  logic [DIV_W:0]    shifted, diff;
  logic              ge, hi_zero, fit, out_free, out_load;
  logic [SPT_W-1:0]  spt_cur, spt_next;

  assign shifted  = {rem_r, work_r[TOT_W-1]};
  assign diff     = shifted - {1'b0, dvs_r};
  assign ge       = shifted >= {1'b0, dvs_r};
  assign hi_zero  = (work_r[TOT_W-1:CYL_W] == '0);
  assign spt_cur  = spt_of(sidx_r);
  assign spt_next = spt_of(sidx_r + 2'd1);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (small_r) begin
      fit = (work_r <= CYL_SMALL_MAX);
    end else begin
      fit = (work_r < CYL_LIM_A) || ((work_r < CYL_LIM_B) && (head_r >= HEAD_WIDE))
            || hi_zero;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    tot_nxt       = tot_r;
    small_nxt     = small_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    sidx_nxt      = sidx_r;
    head_nxt      = head_r;
    res_valid_nxt = res_valid_r;
    res_cyl_nxt   = res_cyl_r;
    res_head_nxt  = res_head_r;
    res_spt_nxt   = res_spt_r;
    in_ch.ready   = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          tot_nxt   = in_ch.size_bytes[SIZE_W-1:SEC_SHIFT];
          small_nxt = (in_ch.size_bytes <= SMALL_LIMIT);
          work_nxt  = in_ch.size_bytes[SIZE_W-1:SEC_SHIFT];
          rem_nxt   = '0;
          cnt_nxt   = '0;
          sidx_nxt  = SPT_IDX_FIRST;
          head_nxt  = HEAD_MIN;
          dvs_nxt   = {2'b00, spt_of(SPT_IDX_FIRST), 2'b00};
          if (in_ch.size_bytes == '0) begin
            res_valid_nxt = 1'b0;
            res_cyl_nxt   = '0;
            res_head_nxt  = '0;
            res_spt_nxt   = '0;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        work_nxt = {work_r[TOT_W-2:0], ge};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (fit) begin
          res_valid_nxt = 1'b1;
          res_cyl_nxt   = work_r[CYL_W-1:0];
          res_head_nxt  = head_r;
          res_spt_nxt   = spt_cur;
          state_nxt     = S_DONE;
        end else if (head_r == HEAD_MAX && sidx_r == SPT_IDX_LAST) begin
          // no fit at all: report last trial, cylinders saturated if above 16 bits
          res_valid_nxt = 1'b1;
          res_cyl_nxt   = hi_zero ? work_r[CYL_W-1:0] : CYL_SAT;
          res_head_nxt  = HEAD_MAX;
          res_spt_nxt   = SPT_255;
          state_nxt     = S_DONE;
        end else begin
          if (head_r == HEAD_MAX) begin
            sidx_nxt = sidx_r + 2'd1;
            head_nxt = HEAD_MIN;
            dvs_nxt  = {2'b00, spt_next, 2'b00};
          end else begin
            head_nxt = head_r + 1'b1;
            dvs_nxt  = dvs_r + {4'b0000, spt_cur};
          end
          work_nxt  = tot_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tot_r       <= tot_nxt;
    small_r     <= small_nxt;
    work_r      <= work_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    cnt_r       <= cnt_nxt;
    sidx_r      <= sidx_nxt;
    head_r      <= head_nxt;
    res_valid_r <= res_valid_nxt;
    res_cyl_r   <= res_cyl_nxt;
    res_head_r  <= res_head_nxt;
    res_spt_r   <= res_spt_nxt;
    if (out_load) begin
      out_vres_r <= res_valid_r;
      out_cyl_r  <= res_cyl_r;
      out_head_r <= res_head_r;
      out_spt_r  <= res_spt_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.valid_res         = out_vres_r;
  assign out_ch.cylinders         = out_cyl_r;
  assign out_ch.heads             = out_head_r;
  assign out_ch.sectors_per_track = out_spt_r;

endmodule

// ===== sv/hcg_checker.sv =====
// hcg_checker: port-level assertions for hardfile_chs_geometry, plus the bind.
// Depends on hcg_pkg; the bind reaches into the hcg_in_if and hcg_out_if ports of the top level.
module hcg_checker import hcg_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_valid_res,
  input logic [CYL_W-1:0]  out_cylinders,
  input logic [HEAD_W-1:0] out_heads,
  input logic [SPT_W-1:0]  out_spt
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_valid_res) && $stable(out_cylinders)
      && $stable(out_heads) && $stable(out_spt))
    else $error("result changed while stalled");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_cylinders == '0 && out_heads == '0
      && out_spt == '0)
    else $error("invalid geometry with nonzero fields");

  a_geom_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_heads >= HEAD_MIN && out_heads <= HEAD_MAX
      && (out_spt == SPT_63 || out_spt == SPT_127 || out_spt == SPT_255))
    else $error("geometry out of range");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind hardfile_chs_geometry hcg_checker u_hcg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_valid_res (out_ch.valid_res),
  .out_cylinders (out_ch.cylinders),
  .out_heads     (out_ch.heads),
  .out_spt       (out_ch.sectors_per_track)
);
